// ===== hdl/qsu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsu_pkg - shared types and constants for the quoted string unescape unit
// Character codes, parse phases and the transfer payload structs.
// ----------------------------------------------------------------------------
package qsu_pkg;

  localparam int unsigned MaxLenW   = 11;
  localparam int unsigned CountW    = 16;
  localparam logic [MaxLenW-1:0] MaxLenReset = 11'd256;

  // character codes
  localparam logic [7:0] ChrNul    = 8'h00;
  localparam logic [7:0] ChrTab    = 8'h09;
  localparam logic [7:0] ChrSpace  = 8'h20;
  localparam logic [7:0] ChrQuote  = 8'h22;
  localparam logic [7:0] ChrBslash = 8'h5c;
  localparam logic [7:0] ChrLowerX = 8'h78;
  localparam logic [7:0] ChrDig0   = 8'h30;
  localparam logic [7:0] ChrDig7   = 8'h37;
  localparam logic [7:0] ChrDig9   = 8'h39;
  localparam logic [7:0] ChrUpperA = 8'h41;
  localparam logic [7:0] ChrUpperF = 8'h46;
  localparam logic [7:0] ChrLowerA = 8'h61;
  localparam logic [7:0] ChrLowerF = 8'h66;
  localparam logic [7:0] ChrLowerB = 8'h62;
  localparam logic [7:0] ChrLowerT = 8'h74;
  localparam logic [7:0] ChrLowerN = 8'h6e;
  localparam logic [7:0] ChrLowerV = 8'h76;
  localparam logic [7:0] ChrLowerR = 8'h72;

  // digit offsets: '0', 'A'-10, 'a'-10
  localparam logic [7:0] OffDigit = 8'h30;
  localparam logic [7:0] OffUpper = 8'h37;
  localparam logic [7:0] OffLower = 8'h57;

  // decoded control characters
  localparam logic [7:0] CtlBel = 8'h07;
  localparam logic [7:0] CtlBs  = 8'h08;
  localparam logic [7:0] CtlHt  = 8'h09;
  localparam logic [7:0] CtlLf  = 8'h0a;
  localparam logic [7:0] CtlVt  = 8'h0b;
  localparam logic [7:0] CtlFf  = 8'h0c;
  localparam logic [7:0] CtlCr  = 8'h0d;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_VAL   = 3'd1,
    PH_ESC   = 3'd2,
    PH_HEX   = 3'd3,
    PH_OCT   = 3'd4,
    PH_DONE  = 3'd5,
    PH_ERR   = 3'd6
  } phase_e;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       start_new;
  } in_item_t;

  typedef struct packed {
    logic              out_valid;
    logic [7:0]        out_byte;
    logic              done_res;
    logic              error;
    logic [CountW-1:0] consumed;
  } out_item_t;

endpackage

// ===== hdl/qsu_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsu_decode - parse state and per-byte decode
// Holds the parse state and works out the result for one byte in one pass.
// ----------------------------------------------------------------------------
module qsu_decode #(
  parameter int unsigned LEN_LIMIT = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  qsu_pkg::in_item_t            item_i,
  input  logic [qsu_pkg::MaxLenW-1:0]  max_len_i,
  output qsu_pkg::out_item_t           res_o
);

  localparam logic [16:0] LenLimitW = 17'(LEN_LIMIT);

  qsu_pkg::phase_e             phase_q, phase_d;
  logic [1:0]                  dcnt_q, dcnt_d;
  logic [7:0]                  acc_q, acc_d;
  logic [qsu_pkg::MaxLenW-1:0] ocnt_q, ocnt_d;
  logic [qsu_pkg::CountW-1:0]  icnt_q, icnt_d;
  logic [qsu_pkg::MaxLenW-1:0] lim;
  logic                        emit;
  logic [7:0]                  obyte;
  logic [4:0]                  hex_val;
  logic [7:0]                  b;
  logic                        is_oct;

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] t;
    begin
      t = 8'h00;
      if (c >= qsu_pkg::ChrDig0 && c <= qsu_pkg::ChrDig9) begin
        t = c - qsu_pkg::OffDigit;
      end else if (c >= qsu_pkg::ChrUpperA && c <= qsu_pkg::ChrUpperF) begin
        t = c - qsu_pkg::OffUpper;
      end else if (c >= qsu_pkg::ChrLowerA && c <= qsu_pkg::ChrLowerF) begin
        t = c - qsu_pkg::OffLower;
      end else begin
        t = 8'h10;
      end
      return t[4:0];
    end
  endfunction

  assign b       = item_i.byte_in;
  assign is_oct  = (b >= qsu_pkg::ChrDig0) && (b <= qsu_pkg::ChrDig7);
  assign hex_val = hex_digit(b);
  assign lim     = ({6'd0, max_len_i} > LenLimitW) ? LenLimitW[qsu_pkg::MaxLenW-1:0]
                                                   : max_len_i;

  always_comb begin
    phase_d = phase_q;
    dcnt_d  = dcnt_q;
    acc_d   = acc_q;
    ocnt_d  = ocnt_q;
    icnt_d  = icnt_q;
    emit    = 1'b0;
    obyte   = 8'h00;

    if (item_i.start_new) begin
      phase_d = qsu_pkg::PH_START;
      dcnt_d  = 2'd0;
      acc_d   = 8'h00;
      ocnt_d  = '0;
      icnt_d  = '0;
    end

    if (phase_d != qsu_pkg::PH_DONE && phase_d != qsu_pkg::PH_ERR) begin
      if (ocnt_d >= lim || b == qsu_pkg::ChrNul) begin
        phase_d = qsu_pkg::PH_ERR;
      end else begin
        if (icnt_d != '1) begin
          icnt_d = icnt_d + 1'b1;
        end
        case (phase_d)
          qsu_pkg::PH_START: begin
            if (b == qsu_pkg::ChrQuote) begin
              phase_d = qsu_pkg::PH_VAL;
            end else if (b != qsu_pkg::ChrSpace && b != qsu_pkg::ChrTab) begin
              phase_d = qsu_pkg::PH_ERR;
            end
          end
          qsu_pkg::PH_VAL: begin
            if (b == qsu_pkg::ChrQuote) begin
              phase_d = qsu_pkg::PH_DONE;
            end else if (b == qsu_pkg::ChrBslash) begin
              phase_d = qsu_pkg::PH_ESC;
            end else begin
              emit  = 1'b1;
              obyte = b;
            end
          end
          qsu_pkg::PH_ESC: begin
            if (b == qsu_pkg::ChrLowerX) begin
              dcnt_d  = 2'd0;
              acc_d   = 8'h00;
              phase_d = qsu_pkg::PH_HEX;
            end else if (is_oct) begin
              // first octal digit counts as the first of three
              dcnt_d  = 2'd1;
              acc_d   = {5'd0, b[2:0]};
              phase_d = qsu_pkg::PH_OCT;
            end else begin
              emit    = 1'b1;
              phase_d = qsu_pkg::PH_VAL;
              case (b)
                qsu_pkg::ChrLowerA: obyte = qsu_pkg::CtlBel;
                qsu_pkg::ChrLowerB: obyte = qsu_pkg::CtlBs;
                qsu_pkg::ChrLowerT: obyte = qsu_pkg::CtlHt;
                qsu_pkg::ChrLowerN: obyte = qsu_pkg::CtlLf;
                qsu_pkg::ChrLowerV: obyte = qsu_pkg::CtlVt;
                qsu_pkg::ChrLowerF: obyte = qsu_pkg::CtlFf;
                qsu_pkg::ChrLowerR: obyte = qsu_pkg::CtlCr;
                default:            obyte = b;
              endcase
            end
          end
          qsu_pkg::PH_HEX: begin
            if (hex_val[4]) begin
              phase_d = qsu_pkg::PH_ERR;
            end else begin
              acc_d  = {acc_d[3:0], hex_val[3:0]};
              dcnt_d = dcnt_d + 2'd1;
              if (dcnt_d >= 2'd2) begin
                emit    = 1'b1;
                obyte   = acc_d;
                phase_d = qsu_pkg::PH_VAL;
              end
            end
          end
          qsu_pkg::PH_OCT: begin
            if (is_oct) begin
              // keep the low 8 bits, as the escape truncates
              acc_d  = {acc_d[4:0], b[2:0]};
              dcnt_d = dcnt_d + 2'd1;
              if (dcnt_d >= 2'd3) begin
                emit    = 1'b1;
                obyte   = acc_d;
                phase_d = qsu_pkg::PH_VAL;
              end
            end else begin
              phase_d = qsu_pkg::PH_ERR;
            end
          end
          default: begin
            phase_d = qsu_pkg::PH_ERR;
          end
        endcase
        if (emit) begin
          ocnt_d = ocnt_d + 1'b1;
          if (ocnt_d >= lim && phase_d != qsu_pkg::PH_DONE) begin
            phase_d = qsu_pkg::PH_ERR;
          end
        end
      end
    end

    res_o.out_valid = emit;
    res_o.out_byte  = obyte;
    res_o.done_res  = (phase_d == qsu_pkg::PH_DONE);
    res_o.error     = (phase_d == qsu_pkg::PH_ERR);
    res_o.consumed  = (phase_d == qsu_pkg::PH_DONE) ? icnt_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= qsu_pkg::PH_START;
      dcnt_q  <= 2'd0;
      acc_q   <= 8'h00;
      ocnt_q  <= '0;
      icnt_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      dcnt_q  <= dcnt_d;
      acc_q   <= acc_d;
      ocnt_q  <= ocnt_d;
      icnt_q  <= icnt_d;
    end
  end

  // a failed parse stays failed until a new one is started
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && phase_q == qsu_pkg::PH_ERR && !item_i.start_new)
      |=> (phase_q == qsu_pkg::PH_ERR))
    else $error("qsu_decode: left error phase without start_new");

  // a finished string has taken at least both quotes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && res_o.done_res) |-> (res_o.consumed >= 16'd2))
    else $error("qsu_decode: done with fewer than two bytes consumed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |-> !(res_o.out_valid && (res_o.done_res || !(res_o.consumed == '0))))
    else $error("qsu_decode: byte emitted together with done");

  // emitted bytes never pass the buffer limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && res_o.out_valid) |=> (ocnt_q <= $past(lim)))
    else $error("qsu_decode: output count beyond limit");

endmodule

// ===== hdl/qsu_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsu_out_buf - result register with skid stage
// Holds one result on the port and one more behind it while the sink stalls.
// ----------------------------------------------------------------------------
module qsu_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  qsu_pkg::out_item_t push_data_i,
  output logic               full_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output qsu_pkg::out_item_t out_data_o
);

  logic               head_vld_q, head_vld_d;
  logic               skid_vld_q, skid_vld_d;
  qsu_pkg::out_item_t head_q, head_d;
  qsu_pkg::out_item_t skid_q, skid_d;
  logic               take;

  assign take = head_vld_q && !out_stall_i;

  always_comb begin
    head_vld_d = head_vld_q;
    skid_vld_d = skid_vld_q;
    head_d     = head_q;
    skid_d     = skid_q;
    if (push_i) begin
      // a push only happens with the skid stage empty
      if (!head_vld_q || take) begin
        head_d     = push_data_i;
        head_vld_d = 1'b1;
      end else begin
        skid_d     = push_data_i;
        skid_vld_d = 1'b1;
      end
    end else if (take) begin
      if (skid_vld_q) begin
        head_d     = skid_q;
        skid_vld_d = 1'b0;
      end else begin
        head_vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      head_vld_q <= head_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_vld_q;
  assign out_valid_o = head_vld_q;
  assign out_data_o  = head_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> head_vld_q)
    else $error("qsu_out_buf: skid entry without head entry");

  // a result parked in the skid stage moves to the port when the head drains
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_vld_q && take) |=> (head_vld_q && head_q == $past(skid_q) && !skid_vld_q))
    else $error("qsu_out_buf: skid entry lost");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_vld_q)
    else $error("qsu_out_buf: push into full buffer");

endmodule

// ===== hdl/quoted_string_unescape_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_string_unescape_unit - streaming C string literal unescaper
// Takes one source byte per transfer and returns one result per byte.
// ----------------------------------------------------------------------------
// The result of a byte is registered in the head entry of the result buffer, or in the skid entry.
// Throughput: one byte per cycle while the skid entry is free; the parse state updates in a single pass.
// A two-entry result buffer takes one more result during output stall; in_stall rises once it fills.
// Reset clears the parse state and both result entries; max_len returns to 256.
module quoted_string_unescape_unit #(
  parameter int unsigned LEN_LIMIT = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  qsu_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output qsu_pkg::out_item_t           out_data_o,
  input  logic                         cfg_we_i,
  input  logic [qsu_pkg::MaxLenW-1:0]  cfg_wdata_i
);

  logic [qsu_pkg::MaxLenW-1:0] max_len_q;
  logic                        accept;
  logic                        buf_full;
  qsu_pkg::out_item_t          res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= qsu_pkg::MaxLenReset;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  qsu_decode #(
    .LEN_LIMIT (LEN_LIMIT)
  ) u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .item_i    (in_data_i),
    .max_len_i (max_len_q),
    .res_o     (res)
  );

  qsu_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== sim/qsu_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsu_result_checker - decode predictor and result comparator
// Watches the source, result and max_len ports of the unescape unit. Each
// accepted source byte is decoded here in step with the unit, and every
// accepted result is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module qsu_result_checker #(
  parameter int unsigned LEN_LIMIT = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  qsu_pkg::in_item_t           in_data_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  qsu_pkg::out_item_t          out_data_i,
  input  logic                        cfg_we_i,
  input  logic [qsu_pkg::MaxLenW-1:0] cfg_wdata_i,
  output int unsigned                 mismatches_o,
  output int unsigned                 backlog_o,
  output int unsigned                 results_o
);

  logic [qsu_pkg::MaxLenW-1:0] max_len;
  qsu_pkg::phase_e             phase;
  logic [1:0]                  digit_cnt;
  logic [7:0]                  acc;
  int unsigned                 out_cnt;
  logic [qsu_pkg::CountW-1:0]  in_cnt;

  qsu_pkg::out_item_t decoded_q[$];
  qsu_pkg::out_item_t head;
  qsu_pkg::out_item_t fresh;
  int unsigned mismatches = 0;
  int unsigned results = 0;
  int unsigned backlog = 0;

  assign mismatches_o = mismatches;
  assign backlog_o    = backlog;
  assign results_o    = results;

  task automatic clear_parse();
    phase     = qsu_pkg::PH_START;
    digit_cnt = '0;
    acc       = '0;
    out_cnt   = 0;
    in_cnt    = '0;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: result %0d, %s: got 0x%0h, want 0x%0h", $time, results, what, got,
             want);
    mismatches++;
  endtask

  // Advance the decode state by one source byte and form the result it gives.
  task automatic unescape_byte(input qsu_pkg::in_item_t item,
                               output qsu_pkg::out_item_t res);
    int unsigned lim;
    logic [7:0]  b;
    logic [7:0]  ob;
    logic [7:0]  dv;
    logic        emit;
    logic        hex_ok;
    b    = item.byte_in;
    ob   = '0;
    dv   = '0;
    emit = 1'b0;
    lim  = (max_len > LEN_LIMIT) ? LEN_LIMIT : max_len;
    if (item.start_new) clear_parse();

    if (phase != qsu_pkg::PH_DONE && phase != qsu_pkg::PH_ERR) begin
      if (out_cnt >= lim || b == qsu_pkg::ChrNul) begin
        phase = qsu_pkg::PH_ERR;
      end else begin
        if (in_cnt != '1) in_cnt = in_cnt + 1'b1;
        case (phase)
          qsu_pkg::PH_START: begin
            if (b == qsu_pkg::ChrQuote) phase = qsu_pkg::PH_VAL;
            else if (b != qsu_pkg::ChrSpace && b != qsu_pkg::ChrTab) phase = qsu_pkg::PH_ERR;
          end
          qsu_pkg::PH_VAL: begin
            if (b == qsu_pkg::ChrQuote) begin
              phase = qsu_pkg::PH_DONE;
            end else if (b == qsu_pkg::ChrBslash) begin
              phase = qsu_pkg::PH_ESC;
            end else begin
              emit = 1'b1;
              ob   = b;
            end
          end
          qsu_pkg::PH_ESC: begin
            if (b == qsu_pkg::ChrLowerX) begin
              digit_cnt = '0;
              acc       = '0;
              phase     = qsu_pkg::PH_HEX;
            end else if (b >= qsu_pkg::ChrDig0 && b <= qsu_pkg::ChrDig7) begin
              // first octal digit counts as one of the three
              digit_cnt = 2'd1;
              acc       = b - qsu_pkg::OffDigit;
              phase     = qsu_pkg::PH_OCT;
            end else begin
              emit = 1'b1;
              case (b)
                qsu_pkg::ChrLowerA: ob = qsu_pkg::CtlBel;
                qsu_pkg::ChrLowerB: ob = qsu_pkg::CtlBs;
                qsu_pkg::ChrLowerT: ob = qsu_pkg::CtlHt;
                qsu_pkg::ChrLowerN: ob = qsu_pkg::CtlLf;
                qsu_pkg::ChrLowerV: ob = qsu_pkg::CtlVt;
                qsu_pkg::ChrLowerF: ob = qsu_pkg::CtlFf;
                qsu_pkg::ChrLowerR: ob = qsu_pkg::CtlCr;
                default:            ob = b;
              endcase
              phase = qsu_pkg::PH_VAL;
            end
          end
          qsu_pkg::PH_HEX: begin
            hex_ok = 1'b1;
            if (b >= qsu_pkg::ChrDig0 && b <= qsu_pkg::ChrDig9)
              dv = b - qsu_pkg::OffDigit;
            else if (b >= qsu_pkg::ChrUpperA && b <= qsu_pkg::ChrUpperF)
              dv = b - qsu_pkg::OffUpper;
            else if (b >= qsu_pkg::ChrLowerA && b <= qsu_pkg::ChrLowerF)
              dv = b - qsu_pkg::OffLower;
            else hex_ok = 1'b0;
            if (!hex_ok) begin
              phase = qsu_pkg::PH_ERR;
            end else begin
              acc       = {acc[3:0], dv[3:0]};
              digit_cnt = digit_cnt + 2'd1;
              if (digit_cnt >= 2'd2) begin
                emit  = 1'b1;
                ob    = acc;
                phase = qsu_pkg::PH_VAL;
              end
            end
          end
          qsu_pkg::PH_OCT: begin
            if (b >= qsu_pkg::ChrDig0 && b <= qsu_pkg::ChrDig7) begin
              // keep the low 8 bits only
              acc       = {acc[4:0], b[2:0]};
              digit_cnt = digit_cnt + 2'd1;
              if (digit_cnt >= 2'd3) begin
                emit  = 1'b1;
                ob    = acc;
                phase = qsu_pkg::PH_VAL;
              end
            end else begin
              phase = qsu_pkg::PH_ERR;
            end
          end
          default: phase = qsu_pkg::PH_ERR;
        endcase
        if (emit) begin
          out_cnt++;
          if (out_cnt >= lim && phase != qsu_pkg::PH_DONE) phase = qsu_pkg::PH_ERR;
        end
      end
    end

    res.out_valid = emit;
    res.out_byte  = ob;
    res.done_res  = (phase == qsu_pkg::PH_DONE);
    res.error     = (phase == qsu_pkg::PH_ERR);
    res.consumed  = (phase == qsu_pkg::PH_DONE) ? in_cnt : '0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len = qsu_pkg::MaxLenReset;
      clear_parse();
      decoded_q.delete();
    end else begin
      // results leave before this edge's source byte is decoded
      if (out_valid_i && !out_stall_i) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("result with nothing outstanding", 32'(out_data_i), '0);
        end else begin
          head = decoded_q.pop_front();
          if (out_data_i.out_valid !== head.out_valid)
            report_mismatch("out_valid", 32'(out_data_i.out_valid), 32'(head.out_valid));
          if (out_data_i.out_byte !== head.out_byte)
            report_mismatch("out_byte", 32'(out_data_i.out_byte), 32'(head.out_byte));
          if (out_data_i.done_res !== head.done_res)
            report_mismatch("done_res", 32'(out_data_i.done_res), 32'(head.done_res));
          if (out_data_i.error !== head.error)
            report_mismatch("error", 32'(out_data_i.error), 32'(head.error));
          if (out_data_i.consumed !== head.consumed)
            report_mismatch("consumed", 32'(out_data_i.consumed), 32'(head.consumed));
        end
        results++;
      end
      if (in_valid_i && !in_stall_i) begin
        unescape_byte(in_data_i, fresh);
        decoded_q.insert(decoded_q.size(), fresh);
      end
      if (cfg_we_i) max_len = cfg_wdata_i;
    end
    backlog = decoded_q.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - testbench for the quoted string unescape unit
// Feeds directed and random string literals, well-formed and broken, under
// a range of max_len settings and stall mixes; the checker beside the unit
// predicts each result and counts mismatches for the verdict.
// ----------------------------------------------------------------------------
module tb_top;

  typedef enum int {
    FLT_NONE,
    FLT_STRAY,
    FLT_NUL,
    FLT_HEX,
    FLT_OCT,
    FLT_OPEN
  } fault_e;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  qsu_pkg::in_item_t           in_data;
  logic                        out_valid;
  logic                        out_stall;
  qsu_pkg::out_item_t          out_data;
  logic                        cfg_we;
  logic [qsu_pkg::MaxLenW-1:0] cfg_wdata;

  int unsigned mismatches;
  int unsigned backlog;
  int unsigned results;

  int   gap_pct = 0;
  int   stall_pct = 0;
  logic restart = 1'b0;
  int   bytes_sent = 0;
  int   literals = 0;

  quoted_string_unescape_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  qsu_result_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .mismatches_o (mismatches),
    .backlog_o    (backlog),
    .results_o    (results)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic logic [7:0] hex_char(input int d);
    if (d < 10) return qsu_pkg::ChrDig0 + 8'(d);
    return ($urandom_range(1) ? qsu_pkg::ChrUpperA : qsu_pkg::ChrLowerA) + 8'(d - 10);
  endfunction

  // Offer one source byte and hold it until the transfer happens.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{byte_in: b, start_new: restart};
    restart = 1'b0;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // bytes after done or error leave the parse state of the unit unchanged
  task automatic send_noise();
    repeat ($urandom_range(2)) send_byte(8'($urandom));
  endtask

  // Drain all outstanding results, then write max_len.
  task automatic write_max_len(input logic [qsu_pkg::MaxLenW-1:0] v);
    in_valid <= 1'b0;
    do @(posedge clk); while (backlog != 0);
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_literal(input int len, input fault_e fault);
    int         at;
    logic [7:0] b;
    restart = 1'b1;
    literals++;
    repeat ($urandom_range(3) == 0 ? $urandom_range(1, 3) : 0) begin
      send_byte($urandom_range(1) ? qsu_pkg::ChrSpace : qsu_pkg::ChrTab);
    end
    if (fault == FLT_STRAY) begin
      do b = 8'($urandom);
      while (b == qsu_pkg::ChrSpace || b == qsu_pkg::ChrTab || b == qsu_pkg::ChrQuote);
      send_byte(b);
      send_noise();
      return;
    end
    send_byte(qsu_pkg::ChrQuote);
    at = $urandom_range(len);
    for (int i = 0; i <= len; i++) begin
      if (fault != FLT_NONE && i == at) begin
        case (fault)
          FLT_NUL: send_byte(qsu_pkg::ChrNul);
          FLT_HEX: begin
            send_byte(qsu_pkg::ChrBslash);
            send_byte(qsu_pkg::ChrLowerX);
            if ($urandom_range(1)) send_byte(hex_char($urandom_range(15)));
            do b = 8'($urandom);
            while ((b >= qsu_pkg::ChrDig0 && b <= qsu_pkg::ChrDig9) ||
                   (b >= qsu_pkg::ChrUpperA && b <= qsu_pkg::ChrUpperF) ||
                   (b >= qsu_pkg::ChrLowerA && b <= qsu_pkg::ChrLowerF));
            send_byte(b);
          end
          FLT_OCT: begin
            send_byte(qsu_pkg::ChrBslash);
            send_byte(qsu_pkg::ChrDig0 + 8'($urandom_range(7)));
            if ($urandom_range(1)) send_byte(qsu_pkg::ChrDig0 + 8'($urandom_range(7)));
            do b = 8'($urandom); while (b >= qsu_pkg::ChrDig0 && b <= qsu_pkg::ChrDig7);
            send_byte(b);
          end
          default: ;
        endcase
        // an open literal is left for the next start_new to cut short
        if (fault != FLT_OPEN) send_noise();
        return;
      end
      if (i < len) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4: begin
            do b = 8'($urandom_range(1, 255));
            while (b == qsu_pkg::ChrQuote || b == qsu_pkg::ChrBslash);
            send_byte(b);
          end
          5, 6: begin
            send_byte(qsu_pkg::ChrBslash);
            case ($urandom_range(6))
              0:       send_byte(qsu_pkg::ChrLowerA);
              1:       send_byte(qsu_pkg::ChrLowerB);
              2:       send_byte(qsu_pkg::ChrLowerT);
              3:       send_byte(qsu_pkg::ChrLowerN);
              4:       send_byte(qsu_pkg::ChrLowerV);
              5:       send_byte(qsu_pkg::ChrLowerF);
              default: send_byte(qsu_pkg::ChrLowerR);
            endcase
          end
          7: begin
            send_byte(qsu_pkg::ChrBslash);
            send_byte(qsu_pkg::ChrLowerX);
            repeat (2) send_byte(hex_char($urandom_range(15)));
          end
          8: begin
            send_byte(qsu_pkg::ChrBslash);
            repeat (3) send_byte(qsu_pkg::ChrDig0 + 8'($urandom_range(7)));
          end
          default: begin
            do b = 8'($urandom_range(1, 255));
            while (b == qsu_pkg::ChrLowerX ||
                   (b >= qsu_pkg::ChrDig0 && b <= qsu_pkg::ChrDig7));
            send_byte(qsu_pkg::ChrBslash);
            send_byte(b);
          end
        endcase
      end
    end
    send_byte(qsu_pkg::ChrQuote);
    if ($urandom_range(3) == 0) send_noise();
  endtask

  initial begin : stimulus
    int     target;
    int     mode_gap;
    int     mode_stall;
    int     len;
    int     r;
    fault_e fault;
    logic   calm;
    logic [qsu_pkg::MaxLenW-1:0] setting;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    gap_pct   = 6;
    stall_pct = 88;

    // blanks, all-ones byte, named escape, hex, truncated octal, then ignored byte
    restart = 1'b1;
    send_byte(qsu_pkg::ChrSpace);
    send_byte(qsu_pkg::ChrTab);
    send_byte(qsu_pkg::ChrQuote);
    send_byte(8'hff);
    send_byte(qsu_pkg::ChrBslash);
    send_byte(qsu_pkg::ChrLowerN);
    send_byte(qsu_pkg::ChrBslash);
    send_byte(qsu_pkg::ChrLowerX);
    send_byte(qsu_pkg::ChrLowerA);
    send_byte(qsu_pkg::ChrUpperF);
    send_byte(qsu_pkg::ChrBslash);
    repeat (3) send_byte(qsu_pkg::ChrDig7);
    send_byte(qsu_pkg::ChrQuote);
    send_byte(8'h5a);
    // stray byte before the opening quote
    restart = 1'b1;
    send_byte(8'h51);
    // bad hex digit
    restart = 1'b1;
    send_byte(qsu_pkg::ChrQuote);
    send_byte(qsu_pkg::ChrBslash);
    send_byte(qsu_pkg::ChrLowerX);
    send_byte(8'h67);
    // NUL inside the literal
    restart = 1'b1;
    send_byte(qsu_pkg::ChrQuote);
    send_byte(qsu_pkg::ChrNul);
    // buffer full on the emitting byte
    write_max_len(11'd2);
    restart = 1'b1;
    send_byte(qsu_pkg::ChrQuote);
    send_byte(qsu_pkg::ChrLowerA);
    send_byte(qsu_pkg::ChrLowerB);
    // limit lowered below the count mid-parse
    write_max_len(qsu_pkg::MaxLenReset);
    restart = 1'b1;
    send_byte(qsu_pkg::ChrQuote);
    send_byte(qsu_pkg::ChrLowerA);
    send_byte(qsu_pkg::ChrLowerB);
    send_byte(qsu_pkg::ChrLowerF);
    write_max_len(11'd1);
    send_byte(qsu_pkg::ChrLowerN);
    // zero limit
    write_max_len(11'd0);
    restart = 1'b1;
    send_byte(qsu_pkg::ChrSpace);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       setting = 11'd1024;
        1:       setting = 11'd1;
        2:       setting = 11'($urandom_range(3, 40));
        3:       setting = 11'd2047;
        4:       setting = 11'($urandom_range(2, 12));
        default: setting = 11'($urandom_range(41, 1023));
      endcase
      case (p / 2)
        0: begin
          mode_gap   = 6;
          mode_stall = 88;
        end
        1: begin
          mode_gap   = 88;
          mode_stall = 6;
        end
        default: begin
          mode_gap   = 0;
          mode_stall = 0;
        end
      endcase
      write_max_len(setting);
      target = bytes_sent + 78;
      while (bytes_sent < target) begin
        calm      = ($urandom_range(7) == 0);
        gap_pct   = calm ? 0 : mode_gap;
        stall_pct = calm ? 0 : mode_stall;
        r   = $urandom_range(99);
        len = (r < 70) ? $urandom_range(8) :
              (r < 95) ? $urandom_range(9, 30) : $urandom_range(31, 60);
        fault = ($urandom_range(99) < 80) ? FLT_NONE : fault_e'($urandom_range(1, 5));
        send_literal(len, fault);
      end
    end

    gap_pct   = 0;
    stall_pct = 0;
    in_valid <= 1'b0;
    for (int n = 0; n < 20000 && backlog != 0; n++) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d results checked from %0d source bytes over %0d random literals", results,
             bytes_sent, literals);
    $display("max_len 0 to 2047, three stall mixes, directed escape and error cases");
    if (mismatches == 0 && backlog == 0) begin
      $display("PASS");
    end else begin
      if (backlog != 0) $display("%0d predicted results never arrived", backlog);
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("timeout with %0d results outstanding", backlog);
    $display("FAIL");
    $finish;
  end

endmodule
